>>> rtl/pbhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbhs_pkg;

   // register indexes on the csr port, byte address is four times the index
   localparam logic [2:0] CSR_X_LIMIT    = 3'd0;
   localparam logic [2:0] CSR_Y_LIMIT    = 3'd1;
   localparam logic [2:0] CSR_Z_LIMIT    = 3'd2;
   localparam logic [2:0] CSR_RADIUS     = 3'd3;
   localparam logic [2:0] CSR_SATURATION = 3'd4;
   localparam logic [2:0] CSR_BRIGHTNESS = 3'd5;

   localparam logic [14:0] X_LIMIT_RESET    = 15'd12288;
   localparam logic [14:0] Y_LIMIT_RESET    = 15'd6922;
   localparam logic [14:0] Z_LIMIT_RESET    = 15'd7987;
   localparam logic [14:0] RADIUS_RESET     = 15'd614;
   localparam logic [7:0]  SATURATION_RESET = 8'd255;
   localparam logic [7:0]  BRIGHTNESS_RESET = 8'd179;

   // 255 * 65536, the colour denominator, and half of it for rounding
   localparam logic [23:0] HSV_DEN      = 24'd16711680;
   localparam logic [31:0] HSV_DEN_HALF = 32'd8355840;
   // ceil(2^23 / 255): exact quotient by 255 for values below 66052
   localparam logic [15:0] RECIP_255    = 16'd32897;
   localparam logic [15:0] HALF_255     = 16'd127;

   localparam logic [2:0] SECTOR_0 = 3'd0;
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_z;
      logic [15:0]        hue_in;
      logic [11:0]        hue_rate;
   } req_type;

   typedef struct packed {
      logic signed [15:0] new_pos_x;
      logic signed [15:0] new_pos_y;
      logic signed [15:0] new_pos_z;
      logic signed [15:0] new_vel_x;
      logic signed [15:0] new_vel_y;
      logic signed [15:0] new_vel_z;
      logic [15:0]        hue_out;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } rsp_type;

   // motion part of a request as it moves down the pipeline
   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_z;
      logic [15:0]        hue;
   } kin_type;

   function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
      logic signed [16:0] sum;
      sum = {a[15], a} + {b[15], b};
      if (sum[16] != sum[15]) begin
         return sum[16] ? 16'sh8000 : 16'sh7fff;
      end
      return sum[15:0];
   endfunction

   function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] a);
      if (a == 16'sh8000) begin
         return 16'sh7fff;
      end
      return -a;
   endfunction

   // ball edge past the wall on either side, full width so nothing overflows
   function automatic logic wall_hit(input logic signed [15:0] p,
                                     input logic [14:0] r,
                                     input logic [14:0] l);
      logic signed [17:0] pw;
      logic signed [17:0] rw;
      logic signed [17:0] lw;
      pw = {{2{p[15]}}, p};
      rw = {3'b000, r};
      lw = {3'b000, l};
      return ((pw + rw) > lw) || ((pw - rw) < -lw);
   endfunction

endpackage

`default_nettype wire

>>> rtl/particle_bounce_hue_step_core.sv
// a request taken at a clock edge gives its result on rsp_valid/rsp_data after passing
//   through the seven register stages of the colour path
// throughput: one request per cycle, busy never rises and results cannot be held off
// reset: synchronous, active high; empties the pipeline and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module particle_bounce_hue_step_core
   import pbhs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [14:0] x_limit_ff, x_limit_in;
   logic [14:0] y_limit_ff, y_limit_in;
   logic [14:0] z_limit_ff, z_limit_in;
   logic [14:0] radius_ff, radius_in;
   logic [7:0]  sat_ff, sat_in;
   logic [7:0]  bright_ff, bright_in;
   logic        csr_write;

   logic [6:0]  valid_ff, valid_in;

   kin_type     kin1_ff, kin1_in;
   kin_type     kin2_ff, kin2_in;
   kin_type     kin3_ff;
   kin_type     kin4_ff;
   kin_type     kin5_ff;
   kin_type     kin6_ff;

   logic [18:0] h6;
   logic [2:0]  sector2_ff, sector2_in;
   logic [15:0] frac2_ff, frac2_in;
   logic [2:0]  sector3_ff, sector4_ff, sector5_ff, sector6_ff;

   logic [16:0] frac_inv;
   logic [23:0] fs3_ff, fs3_in;
   logic [23:0] gs3_ff, gs3_in;
   logic [15:0] pn3_ff, pn3_in;
   logic [31:0] nq4_ff, nq4_in;
   logic [31:0] nt4_ff, nt4_in;
   logic [15:0] pn4_ff;
   logic [31:0] sum_q, sum_t;
   logic [15:0] mq5_ff, mq5_in;
   logic [15:0] mt5_ff, mt5_in;
   logic [15:0] mp5_ff, mp5_in;
   logic [31:0] prod_q, prod_t, prod_p;
   logic [7:0]  q6_ff, q6_in;
   logic [7:0]  t6_ff, t6_in;
   logic [7:0]  p6_ff, p6_in;

   rsp_type     rsp_ff, rsp_in;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      z_limit_in = z_limit_ff;
      radius_in  = radius_ff;
      sat_in     = sat_ff;
      bright_in  = bright_ff;
      if (csr_write) begin
         case (csr_paddr[4:2])
            CSR_X_LIMIT:    x_limit_in = csr_pwdata[14:0];
            CSR_Y_LIMIT:    y_limit_in = csr_pwdata[14:0];
            CSR_Z_LIMIT:    z_limit_in = csr_pwdata[14:0];
            CSR_RADIUS:     radius_in  = csr_pwdata[14:0];
            CSR_SATURATION: sat_in     = csr_pwdata[7:0];
            CSR_BRIGHTNESS: bright_in  = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         CSR_X_LIMIT:    csr_prdata = {17'd0, x_limit_ff};
         CSR_Y_LIMIT:    csr_prdata = {17'd0, y_limit_ff};
         CSR_Z_LIMIT:    csr_prdata = {17'd0, z_limit_ff};
         CSR_RADIUS:     csr_prdata = {17'd0, radius_ff};
         CSR_SATURATION: csr_prdata = {24'd0, sat_ff};
         CSR_BRIGHTNESS: csr_prdata = {24'd0, bright_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= X_LIMIT_RESET;
         y_limit_ff <= Y_LIMIT_RESET;
         z_limit_ff <= Z_LIMIT_RESET;
         radius_ff  <= RADIUS_RESET;
         sat_ff     <= SATURATION_RESET;
         bright_ff  <= BRIGHTNESS_RESET;
      end else begin
         x_limit_ff <= x_limit_in;
         y_limit_ff <= y_limit_in;
         z_limit_ff <= z_limit_in;
         radius_ff  <= radius_in;
         sat_ff     <= sat_in;
         bright_ff  <= bright_in;
      end
   end

   // ---------------- valid chain ----------------
   assign busy     = 1'b0;
   assign valid_in = {valid_ff[5:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------- stage 1: position step, hue step ----------------
   always_comb begin
      kin1_in.pos_x = sat_add16(req_data.pos_x, req_data.vel_x);
      kin1_in.pos_y = sat_add16(req_data.pos_y, req_data.vel_y);
      kin1_in.pos_z = sat_add16(req_data.pos_z, req_data.vel_z);
      kin1_in.vel_x = req_data.vel_x;
      kin1_in.vel_y = req_data.vel_y;
      kin1_in.vel_z = req_data.vel_z;
      kin1_in.hue   = req_data.hue_in + {4'd0, req_data.hue_rate};
   end

   // ---------------- stage 2: wall test, hue sector ----------------
   always_comb begin
      kin2_in = kin1_ff;
      if (wall_hit(kin1_ff.pos_x, radius_ff, x_limit_ff)) begin
         kin2_in.vel_x = neg_sat16(kin1_ff.vel_x);
      end
      if (wall_hit(kin1_ff.pos_y, radius_ff, y_limit_ff)) begin
         kin2_in.vel_y = neg_sat16(kin1_ff.vel_y);
      end
      if (wall_hit(kin1_ff.pos_z, radius_ff, z_limit_ff)) begin
         kin2_in.vel_z = neg_sat16(kin1_ff.vel_z);
      end
      h6         = {1'b0, kin1_ff.hue, 2'b00} + {2'b00, kin1_ff.hue, 1'b0};
      sector2_in = h6[18:16];
      frac2_in   = h6[15:0];
   end

   // ---------------- stage 3: fraction times saturation ----------------
   always_comb begin
      frac_inv = 17'h10000 - {1'b0, frac2_ff};
      fs3_in   = {8'd0, frac2_ff} * {16'd0, sat_ff};
      gs3_in   = {7'd0, frac_inv} * {16'd0, sat_ff};
      pn3_in   = {8'd0, bright_ff} * {8'd0, 8'd255 - sat_ff};
   end

   // ---------------- stage 4: numerators ----------------
   always_comb begin
      nq4_in = {24'd0, bright_ff} * {8'd0, HSV_DEN - fs3_ff};
      nt4_in = {24'd0, bright_ff} * {8'd0, HSV_DEN - gs3_ff};
   end

   // ---------------- stage 5: rounding, drop the 65536 part of the divisor ----------------
   always_comb begin
      sum_q  = nq4_ff + HSV_DEN_HALF;
      sum_t  = nt4_ff + HSV_DEN_HALF;
      mq5_in = sum_q[31:16];
      mt5_in = sum_t[31:16];
      mp5_in = pn4_ff + HALF_255;
   end

   // ---------------- stage 6: divide by 255 through the reciprocal ----------------
   always_comb begin
      prod_q = {16'd0, mq5_ff} * {16'd0, RECIP_255};
      prod_t = {16'd0, mt5_ff} * {16'd0, RECIP_255};
      prod_p = {16'd0, mp5_ff} * {16'd0, RECIP_255};
      q6_in  = prod_q[30:23];
      t6_in  = prod_t[30:23];
      p6_in  = prod_p[30:23];
   end

   // ---------------- stage 7: sector select into the result register ----------------
   always_comb begin
      rsp_in.new_pos_x = kin6_ff.pos_x;
      rsp_in.new_pos_y = kin6_ff.pos_y;
      rsp_in.new_pos_z = kin6_ff.pos_z;
      rsp_in.new_vel_x = kin6_ff.vel_x;
      rsp_in.new_vel_y = kin6_ff.vel_y;
      rsp_in.new_vel_z = kin6_ff.vel_z;
      rsp_in.hue_out   = kin6_ff.hue;
      case (sector6_ff)
         SECTOR_0: begin
            rsp_in.red = bright_ff; rsp_in.green = t6_ff;     rsp_in.blue = p6_ff;
         end
         SECTOR_1: begin
            rsp_in.red = q6_ff;     rsp_in.green = bright_ff; rsp_in.blue = p6_ff;
         end
         SECTOR_2: begin
            rsp_in.red = p6_ff;     rsp_in.green = bright_ff; rsp_in.blue = t6_ff;
         end
         SECTOR_3: begin
            rsp_in.red = p6_ff;     rsp_in.green = q6_ff;     rsp_in.blue = bright_ff;
         end
         SECTOR_4: begin
            rsp_in.red = t6_ff;     rsp_in.green = p6_ff;     rsp_in.blue = bright_ff;
         end
         default: begin
            rsp_in.red = bright_ff; rsp_in.green = p6_ff;     rsp_in.blue = q6_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kin1_ff    <= kin1_in;
      kin2_ff    <= kin2_in;
      sector2_ff <= sector2_in;
      frac2_ff   <= frac2_in;
      kin3_ff    <= kin2_ff;
      sector3_ff <= sector2_ff;
      fs3_ff     <= fs3_in;
      gs3_ff     <= gs3_in;
      pn3_ff     <= pn3_in;
      kin4_ff    <= kin3_ff;
      sector4_ff <= sector3_ff;
      nq4_ff     <= nq4_in;
      nt4_ff     <= nt4_in;
      pn4_ff     <= pn3_ff;
      kin5_ff    <= kin4_ff;
      sector5_ff <= sector4_ff;
      mq5_ff     <= mq5_in;
      mt5_ff     <= mt5_in;
      mp5_ff     <= mp5_in;
      kin6_ff    <= kin5_ff;
      sector6_ff <= sector5_ff;
      q6_ff      <= q6_in;
      t6_ff      <= t6_in;
      p6_ff      <= p6_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = valid_ff[6];
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 7))
      else $error("result strobe without a request seven cycles earlier");

   a_hue_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hue_out ==
                     16'($past(req_data.hue_in, 7) + {4'd0, $past(req_data.hue_rate, 7)})))
      else $error("hue out of step with its request");

   a_vel_bounce: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.new_vel_x == $past(req_data.vel_x, 7)) ||
                     (rsp_data.new_vel_x == -$past(req_data.vel_x, 7)) ||
                     (rsp_data.new_vel_x == 16'sh7fff)))
      else $error("x velocity neither kept nor reflected");
`endif

endmodule

`default_nettype wire

>>> tb/tb_particle_bounce_hue_step_core.sv
`timescale 1ns / 1ps

module tb_particle_bounce_hue_step_core;
   import pbhs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 250;
   // decoded by paddr but not backed by a register
   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow of the register file, saturation and brightness in the low byte
   logic [14:0] cfg [0:5];

   req_type particle_q [$];
   rsp_type frame_q [$];
   rsp_type want;
   int      gap_left = 0;
   int      calm_left = 0;
   int      error_count = 0;
   int      cycle_count = 0;

   particle_bounce_hue_step_core u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("particle_bounce_hue_step_core verification failed");
         $finish;
      end
   end

   function automatic void bounce_axis(input logic signed [15:0] p,
                                       input logic signed [15:0] v,
                                       input logic [14:0] lim,
                                       output logic signed [15:0] np,
                                       output logic signed [15:0] nv);
      int sum;
      int rad;
      int wall;
      int vel;
      sum = p + v;
      if (sum > 32767) begin
         sum = 32767;
      end else if (sum < -32768) begin
         sum = -32768;
      end
      rad = cfg[CSR_RADIUS];
      wall = lim;
      vel = v;
      if (sum + rad > wall || sum - rad < -wall) begin
         vel = (vel == -32768) ? 32767 : -vel;
      end
      np = sum;
      nv = vel;
   endfunction

   function automatic rsp_type step_particle(input req_type rq);
      rsp_type     rs;
      logic [15:0] hue;
      logic [2:0]  sector;
      longint      hue6;
      longint      frac;
      longint      s;
      longint      v;
      longint      den;
      longint      p;
      longint      q;
      longint      t;
      bounce_axis(rq.pos_x, rq.vel_x, cfg[CSR_X_LIMIT], rs.new_pos_x, rs.new_vel_x);
      bounce_axis(rq.pos_y, rq.vel_y, cfg[CSR_Y_LIMIT], rs.new_pos_y, rs.new_vel_y);
      bounce_axis(rq.pos_z, rq.vel_z, cfg[CSR_Z_LIMIT], rs.new_pos_z, rs.new_vel_z);
      hue = rq.hue_in + rq.hue_rate;
      rs.hue_out = hue;
      hue6 = hue * 6;
      sector = hue6 >> 16;
      frac = hue6 & 65535;
      s = cfg[CSR_SATURATION][7:0];
      v = cfg[CSR_BRIGHTNESS][7:0];
      den = 255 * 65536;
      // round half up on every scaled channel
      p = (v * (255 - s) + 127) / 255;
      q = (v * (den - frac * s) + den / 2) / den;
      t = (v * (den - (65536 - frac) * s) + den / 2) / den;
      case (sector)
         SECTOR_0: begin
            rs.red = v; rs.green = t; rs.blue = p;
         end
         SECTOR_1: begin
            rs.red = q; rs.green = v; rs.blue = p;
         end
         SECTOR_2: begin
            rs.red = p; rs.green = v; rs.blue = t;
         end
         SECTOR_3: begin
            rs.red = p; rs.green = q; rs.blue = v;
         end
         SECTOR_4: begin
            rs.red = t; rs.green = p; rs.blue = v;
         end
         default: begin
            rs.red = v; rs.green = p; rs.blue = q;
         end
      endcase
      return rs;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm_left = $urandom_range(30, 120);
      end
      if (roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [15:0] rand_s16(input int span);
      int val;
      case ($urandom_range(0, 7))
         0: val = $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: val = 32767;
               1: val = -32768;
               2: val = 0;
               default: val = -1;
            endcase
         end
         default: val = int'($urandom_range(0, 2 * span)) - span;
      endcase
      return val;
   endfunction

   // positions range over the box plus the ball radius and a margin past it, so that bounces are frequent
   function automatic logic signed [15:0] near_wall(input logic [14:0] lim);
      int span;
      span = lim + cfg[CSR_RADIUS] + 256;
      if (span > 32767) begin
         span = 32767;
      end
      return rand_s16(span);
   endfunction

   function automatic req_type rand_particle();
      req_type rq;
      rq.pos_x = near_wall(cfg[CSR_X_LIMIT]);
      rq.pos_y = near_wall(cfg[CSR_Y_LIMIT]);
      rq.pos_z = near_wall(cfg[CSR_Z_LIMIT]);
      rq.vel_x = rand_s16(700);
      rq.vel_y = rand_s16(700);
      rq.vel_z = rand_s16(700);
      if ($urandom_range(0, 3) == 0) begin
         rq.hue_in = 65535 - $urandom_range(0, 4095);
      end else begin
         rq.hue_in = $urandom;
      end
      case ($urandom_range(0, 7))
         0: rq.hue_rate = 0;
         1: rq.hue_rate = 4095;
         default: rq.hue_rate = $urandom;
      endcase
      return rq;
   endfunction

   function automatic req_type mk_item(input int px, input int py, input int pz,
                                       input int vx, input int vy, input int vz,
                                       input int hue, input int rate);
      req_type rq;
      rq.pos_x = px;
      rq.pos_y = py;
      rq.pos_z = pz;
      rq.vel_x = vx;
      rq.vel_y = vy;
      rq.vel_z = vz;
      rq.hue_in = hue;
      rq.hue_rate = rate;
      return rq;
   endfunction

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val,
                  act_val);
         error_count++;
      end
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] idx,
                             input logic [31:0] value);
      logic [31:0] got;
      logic [31:0] msk;
      msk = (idx >= CSR_SATURATION) ? 32'h0000_00ff : 32'h0000_7fff;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (csr_pready !== 1'b1) @(negedge clock);
      got = csr_prdata;
      @(posedge clock);
      if (wr) begin
         if (idx <= CSR_BRIGHTNESS) begin
            cfg[idx] = value & msk;
         end
      end else if ((got & msk) !== {17'b0, cfg[idx]}) begin
         $display("%0t: csr readback at index %0d, expected %h actual %h", $time, idx,
                  cfg[idx], got & msk);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // upper bits carry junk, the register keeps only its own width
   task automatic program_reg(input logic [2:0] idx, input int value);
      int shift;
      shift = (idx >= CSR_SATURATION) ? 8 : 15;
      csr_access(1'b1, idx, ($urandom << shift) | value);
      csr_access(1'b0, idx, 32'h0);
   endtask

   task automatic set_box(input int lx, input int ly, input int lz, input int rad,
                          input int sat, input int bri);
      program_reg(CSR_X_LIMIT, lx);
      program_reg(CSR_Y_LIMIT, ly);
      program_reg(CSR_Z_LIMIT, lz);
      program_reg(CSR_RADIUS, rad);
      program_reg(CSR_SATURATION, sat);
      program_reg(CSR_BRIGHTNESS, bri);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (particle_q.size() != 0 || start || frame_q.size() != 0) @(negedge clock);
   endtask

   task automatic run_random(input int count);
      repeat (count) particle_q.push_back(rand_particle());
      wait_drained();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            frame_q.push_back(step_particle(req_data));
            gap_left = pick_gap();
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (particle_q.size() > 0) begin
            req_data <= particle_q.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         if (rsp_valid !== 1'b1 || frame_q.size() == 0) begin
            $display("%0t: result strobe %b with no request outstanding, expected none actual %h",
                     $time, rsp_valid, rsp_data);
            error_count++;
         end else begin
            want = frame_q.pop_front();
            check_field("new_pos_x", want.new_pos_x, rsp_data.new_pos_x);
            check_field("new_pos_y", want.new_pos_y, rsp_data.new_pos_y);
            check_field("new_pos_z", want.new_pos_z, rsp_data.new_pos_z);
            check_field("new_vel_x", want.new_vel_x, rsp_data.new_vel_x);
            check_field("new_vel_y", want.new_vel_y, rsp_data.new_vel_y);
            check_field("new_vel_z", want.new_vel_z, rsp_data.new_vel_z);
            check_field("hue_out", want.hue_out, rsp_data.hue_out);
            check_field("red", want.red, rsp_data.red);
            check_field("green", want.green, rsp_data.green);
            check_field("blue", want.blue, rsp_data.blue);
         end
      end
   end

   initial begin
      int bx;
      int by;
      int bz;
      cfg[CSR_X_LIMIT] = X_LIMIT_RESET;
      cfg[CSR_Y_LIMIT] = Y_LIMIT_RESET;
      cfg[CSR_Z_LIMIT] = Z_LIMIT_RESET;
      cfg[CSR_RADIUS] = RADIUS_RESET;
      cfg[CSR_SATURATION] = SATURATION_RESET;
      cfg[CSR_BRIGHTNESS] = BRIGHTNESS_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // defaults straight out of reset, read back first
      for (int i = 0; i <= CSR_BRIGHTNESS; i++) csr_access(1'b0, i, 32'h0);

      // ball edge exactly on the wall, then one step past it
      bx = cfg[CSR_X_LIMIT] - cfg[CSR_RADIUS];
      by = cfg[CSR_Y_LIMIT] - cfg[CSR_RADIUS];
      bz = cfg[CSR_Z_LIMIT] - cfg[CSR_RADIUS];
      particle_q.push_back(mk_item(0, 0, 0, 0, 0, 0, 0, 0));
      particle_q.push_back(mk_item(32767, 32767, 32767, 32767, 32767, 32767, 65535, 4095));
      particle_q.push_back(mk_item(-32768, -32768, -32768, -32768, -32768, -32768, 65535, 1));
      particle_q.push_back(mk_item(-20000, 20000, 0, -32768, -32768, 32767, 0, 0));
      particle_q.push_back(mk_item(bx - 5, by - 5, bz - 5, 5, 5, 5, 10922, 1));
      particle_q.push_back(mk_item(bx - 5, by - 5, bz - 5, 6, 6, 6, 10923, 0));
      particle_q.push_back(mk_item(5 - bx, 5 - by, 5 - bz, -5, -5, -5, 21845, 0));
      particle_q.push_back(mk_item(5 - bx, 5 - by, 5 - bz, -6, -6, -6, 32768, 0));
      particle_q.push_back(mk_item(32000, -32000, 100, 1000, -1000, -100, 43690, 0));
      particle_q.push_back(mk_item(-1, 1, -1, 1, -1, 1, 54613, 0));
      particle_q.push_back(mk_item(bx, -by, bz, 0, 0, 0, 65535, 0));
      particle_q.push_back(mk_item(bx + 1, -by - 1, bz + 1, 0, 0, 0, 65000, 536));
      particle_q.push_back(mk_item(12345, -12345, 4321, -32768, 32767, -1, 61440, 4095));
      particle_q.push_back(mk_item(-32768, 32767, -32768, 0, 0, 0, 21844, 2048));
      particle_q.push_back(mk_item(0, 0, 0, 32767, -32768, 1, 43691, 1365));
      particle_q.push_back(mk_item(bx - 614, by, -bz, 614, 0, 0, 54612, 2730));
      particle_q.push_back(mk_item(21845, -21846, 10922, 10922, -21846, 21845, 43690, 2730));
      particle_q.push_back(mk_item(-21846, 21845, -10923, -10923, 21845, -21846, 21845, 1365));
      wait_drained();
      run_random(PHASE_ITEMS);

      // widest box with the largest ball, full colour, plus writes to unmapped slots
      set_box(32767, 32767, 32767, 32767, 255, 255);
      csr_access(1'b1, CSR_SPARE_6, $urandom);
      csr_access(1'b1, CSR_SPARE_7, $urandom);
      run_random(PHASE_ITEMS);

      // zero box, zero radius, grey at black
      set_box(0, 0, 0, 0, 0, 0);
      run_random(PHASE_ITEMS);

      repeat (4) begin
         set_box($urandom_range(0, 32767), $urandom_range(0, 16383), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 255));
         run_random(PHASE_ITEMS);
      end

      // catch any stray result after the last one expected
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("particle_bounce_hue_step_core verification clean");
      end else begin
         $display("particle_bounce_hue_step_core verification failed");
      end
      $finish;
   end

endmodule
